@@ rtl/core/pnrt_pkg.sv @@
// Package for the pack number remap table: operation codes, sizes, shared types.
// No dependencies.
package pnrt_pkg;

    localparam int TableEntriesDefault = 1024;
    localparam int NumW  = 32;
    localparam int HighW = 31;
    localparam int TotW  = 11;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_DELETE = 3'd2,
        OP_APPEND = 3'd3,
        OP_RENAME = 3'd4,
        OP_V2R    = 3'd5,
        OP_R2V    = 3'd6,
        OP_SAVEQ  = 3'd7
    } t_op;

    // Result fields handed from the sequencer to the output register.
    typedef struct packed {
        logic signed [NumW-1:0] answer;
        logic                   status;
        logic                   needs_save;
    } t_result;

endpackage

@@ rtl/core/pnrt_mem.sv @@
// Entry storage of the remap table: virtual, real and valid arrays.
// One write port, one registered read port. Depends on pnrt_pkg.
module pnrt_mem #(
    parameter int ENTRIES = pnrt_pkg::TableEntriesDefault,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pnrt_pkg::NumW-1:0]   i_wvirt,
    input  logic [pnrt_pkg::NumW-1:0]   i_wreal,
    input  logic                        i_wvalid,
    input  logic [AW-1:0]               i_raddr,
    output logic [pnrt_pkg::NumW-1:0]   o_rvirt,
    output logic [pnrt_pkg::NumW-1:0]   o_rreal,
    output logic                        o_rvalid
);
    import pnrt_pkg::*;

    logic [NumW-1:0] r_virt  [ENTRIES];
    logic [NumW-1:0] r_real  [ENTRIES];
    logic            r_valid [ENTRIES];

    // Write one entry, read one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_virt[i_waddr]  <= i_wvirt;
            r_real[i_waddr]  <= i_wreal;
            r_valid[i_waddr] <= i_wvalid;
        end
        o_rvirt  <= r_virt[i_raddr];
        o_rreal  <= r_real[i_raddr];
        o_rvalid <= r_valid[i_raddr];
    end

endmodule

@@ rtl/core/pnrt_seq.sv @@
// Sequencer of the remap table: walks the entry memory one index at a time,
// fetch then check, with a shared compare unit. Depends on pnrt_pkg and pnrt_mem.
module pnrt_seq #(
    parameter int ENTRIES = pnrt_pkg::TableEntriesDefault,
    parameter int AW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2:0]                        i_kind,
    input  logic signed [pnrt_pkg::NumW-1:0]  i_first,
    input  logic signed [pnrt_pkg::NumW-1:0]  i_second,
    input  logic                              i_flag,
    output logic                              o_busy,
    output logic                              o_done,
    output pnrt_pkg::t_result                 o_result,
    output logic [CW-1:0]                     o_fill,
    output logic [pnrt_pkg::HighW-1:0]        o_top
);
    import pnrt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CHECK = 6'b000100,
        S_GAP   = 6'b001000,
        S_FETCH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic [HighW-1:0] TopMax = {HighW{1'b1}};

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic signed [NumW-1:0] r_a, n_a, r_b, n_b;
    logic                   r_flag, n_flag;
    logic [CW-1:0]          r_fill, n_fill;
    logic [HighW-1:0]       r_top, n_top;
    logic [CW-1:0]          r_idx, n_idx;
    logic signed [NumW-1:0] r_k, n_k;
    logic signed [NumW-1:0] r_ans, n_ans;
    logic                   r_err, n_err, r_save, n_save;

    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [NumW-1:0]        wvirt, wreal, rvirt, rreal;
    logic                   wvalid, rvalid;

    pnrt_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wvirt (wvirt),
        .i_wreal (wreal),
        .i_wvalid(wvalid),
        .i_raddr (raddr),
        .o_rvirt (rvirt),
        .o_rreal (rreal),
        .o_rvalid(rvalid)
    );

    // Shared compare / arithmetic terms.
    logic signed [NumW:0]   items;
    logic signed [NumW-1:0] sv, sr;
    logic signed [NumW:0]   gap;
    logic [CW:0]            room;
    logic [CW-1:0]          idx_inc;
    logic                   idx_end;

    always_comb begin
        sv      = $signed(rvirt);
        sr      = $signed(rreal);
        items   = {r_b[NumW-1], r_b} - {r_a[NumW-1], r_a} + (NumW+1)'(1);
        gap     = {r_a[NumW-1], r_a} - {sv[NumW-1], sv};
        room    = (CW+1)'(ENTRIES) - {1'b0, r_fill};
        idx_inc = r_idx + CW'(1);
        idx_end = (idx_inc >= r_fill);
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_flag  = r_flag;
        n_fill  = r_fill;
        n_top   = r_top;
        n_idx   = r_idx;
        n_k     = r_k;
        n_ans   = r_ans;
        n_err   = r_err;
        n_save  = r_save;
        we      = 1'b0;
        waddr   = r_idx[AW-1:0];
        wvirt   = rvirt;
        wreal   = rreal;
        wvalid  = rvalid;
        raddr   = r_idx[AW-1:0];

        case (r_state)
            // Accept a transaction and decide the first step.
            S_IDLE: begin
                if (i_start) begin
                    n_op   = t_op'(i_kind);
                    n_a    = i_first;
                    n_b    = i_second;
                    n_flag = i_flag;
                    n_ans  = '0;
                    n_err  = 1'b0;
                    n_save = 1'b0;
                    n_idx  = '0;
                    n_state = S_DONE;
                    case (t_op'(i_kind))
                        OP_LOAD: begin
                            if (r_fill >= CW'(ENTRIES)) begin
                                n_err = 1'b1;
                            end else begin
                                we     = 1'b1;
                                waddr  = r_fill[AW-1:0];
                                wvirt  = i_first;
                                wreal  = i_second;
                                wvalid = i_flag;
                                n_fill = r_fill + CW'(1);
                                if (!i_second[NumW-1]) n_top = i_second[HighW-1:0];
                            end
                        end
                        OP_CLEAR: begin
                            n_fill = '0;
                            n_top  = '0;
                        end
                        OP_DELETE: begin
                            if (i_second < i_first) n_err = 1'b1;
                            else begin
                                n_ans = i_second - i_first + NumW'(1);
                                if (r_fill != '0) n_state = S_FETCH;
                            end
                        end
                        OP_APPEND: begin
                            if (r_fill != '0) begin
                                n_idx   = r_fill - CW'(1);
                                n_state = S_FETCH;
                            end
                        end
                        OP_RENAME: begin
                            if (i_second > i_first ||
                                    (i_first > $signed(NumW'(r_fill)))) begin
                                n_err = 1'b1;
                            end else begin
                                n_err = 1'b1;
                                n_idx = i_first[NumW-1] ? '0 : i_first[CW-1:0];
                                if ((i_first[NumW-1] ? CW'(0) : i_first[CW-1:0]) < r_fill)
                                    n_state = S_FETCH;
                            end
                        end
                        OP_V2R, OP_R2V: begin
                            if (r_fill == '0) begin
                                n_ans = i_first;
                            end else begin
                                n_ans = -NumW'(1);
                                n_err = 1'b1;
                                if (t_op'(i_kind) == OP_V2R && !i_first[NumW-1] &&
                                        i_first != '0) begin
                                    n_idx = (i_first >= $signed(NumW'(r_fill))) ? r_fill :
                                            i_first[CW-1:0];
                                end
                                if (n_idx < r_fill) n_state = S_FETCH;
                            end
                        end
                        default: begin
                            if (r_fill != '0) n_state = S_FETCH;
                        end
                    endcase
                end
            end
            // Present the read address; data arrives next cycle.
            S_FETCH: begin
                n_state = S_CHECK;
            end
            // Compare one entry per visit.
            S_CHECK: begin
                n_state = S_FETCH;
                n_idx   = idx_inc;
                case (r_op)
                    OP_DELETE: begin
                        if (sv >= r_a) begin
                            we = 1'b1;
                            if (sv <= r_b) begin
                                wvirt  = '1;
                                wvalid = 1'b0;
                            end else begin
                                wvirt = sv - items[NumW-1:0];
                            end
                        end
                        if (idx_end) n_state = S_DONE;
                    end
                    OP_APPEND: begin
                        n_state = S_DONE;
                        if (r_a < sv) begin
                            n_err = 1'b1;
                        end else if (r_a != sv) begin
                            if (gap > {{(NumW-CW){1'b0}}, room}) n_err = 1'b1;
                            else begin
                                n_k     = sv + NumW'(1);
                                n_state = S_GAP;
                            end
                        end
                    end
                    OP_RENAME: begin
                        if (sv == r_a) begin
                            we      = 1'b1;
                            wvirt   = r_b;
                            n_err   = 1'b0;
                            n_state = S_DONE;
                        end else if (idx_end) n_state = S_DONE;
                    end
                    OP_V2R, OP_R2V: begin
                        if ((r_op == OP_V2R ? sv : sr) == r_a) begin
                            n_ans   = (r_op == OP_V2R) ? sr : sv;
                            n_err   = 1'b0;
                            n_state = S_DONE;
                        end else if (idx_end) n_state = S_DONE;
                    end
                    default: begin
                        if (rvirt != rreal) begin
                            n_save  = 1'b1;
                            n_state = S_DONE;
                        end else if (idx_end) n_state = S_DONE;
                    end
                endcase
            end
            // Append one gap entry per cycle.
            S_GAP: begin
                we    = 1'b1;
                waddr = r_fill[AW-1:0];
                wvirt = r_k;
                if (r_top != TopMax) n_top = r_top + HighW'(1);
                if (r_k == r_a) begin
                    wreal   = {1'b0, n_top};
                    wvalid  = r_flag;
                    n_state = S_DONE;
                end else begin
                    wreal  = '1;
                    wvalid = 1'b0;
                end
                n_fill = r_fill + CW'(1);
                n_k    = r_k + NumW'(1);
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_top   <= n_top;
        end
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_flag <= n_flag;
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_ans  <= n_ans;
        r_err  <= n_err;
        r_save <= n_save;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_result.answer     = r_ans;
    assign o_result.status     = r_err;
    assign o_result.needs_save = r_save;
    assign o_fill              = r_fill;
    assign o_top               = r_top;

endmodule

@@ rtl/core/pack_number_remap_table.sv @@
// Pack number remap table.
// Input channel: i_valid / o_stall with kind, first_number, second_number and
// entry_flag. Output channel: o_valid / i_stall carries one result per
// transaction: answer, status, needs_save, highest_real and entry_total.
// Load and clear finish without walking the memory. Range delete, lookups, rename
// and save query walk the entry memory, each entry visited by a fetch state
// and then a check state (registered read port of the entry memory).
// Append fetches the last entry and then writes the gap entries one by one.
// One transaction is in work at a time; o_stall is high while the sequencer
// runs or a result waits in the output register.
// Reset (synchronous, active low) empties the table and clears the highest
// real number; entry contents are not cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and the
// block takes no new transaction until it is taken.
// Depends on pnrt_pkg, pnrt_seq, pnrt_mem.
module pack_number_remap_table #(
    parameter int TABLE_ENTRIES = pnrt_pkg::TableEntriesDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [2:0]                         i_kind,
    input  logic signed [pnrt_pkg::NumW-1:0]   i_first_number,
    input  logic signed [pnrt_pkg::NumW-1:0]   i_second_number,
    input  logic                               i_entry_flag,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [pnrt_pkg::NumW-1:0]   o_answer,
    output logic                               o_status,
    output logic                               o_needs_save,
    output logic [pnrt_pkg::HighW-1:0]         o_highest_real,
    output logic [pnrt_pkg::TotW-1:0]          o_entry_total
);
    import pnrt_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic            busy, done, start;
    t_result         res;
    logic [CW-1:0]   fill;
    logic [HighW-1:0] top;
    logic            r_ovalid;

    assign o_stall = busy || r_ovalid;
    assign start   = i_valid && !o_stall;

    pnrt_seq #(.ENTRIES(TABLE_ENTRIES)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_first (i_first_number),
        .i_second(i_second_number),
        .i_flag  (i_entry_flag),
        .o_busy  (busy),
        .o_done  (done),
        .o_result(res),
        .o_fill  (fill),
        .o_top   (top)
    );

    // Hold the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (done) begin
            o_answer       <= res.answer;
            o_status       <= res.status;
            o_needs_save   <= res.needs_save;
            o_highest_real <= top;
            o_entry_total  <= TotW'(fill);
        end
    end

    assign o_valid = r_ovalid;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy) else $error("start did not launch sequencer");
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !r_ovalid) else $error("result overwritten");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= CW'(TABLE_ENTRIES)) else $error("fill count overflow");
`endif

endmodule
